[hw/rtl/keyframe_linear_interpolator_top_assert.svh]
// Assertion macros for the keyframe interpolator top level.
// No dependencies; the top level takes this file by include.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// a holds at an edge, so b holds at the same edge
`define KLI_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("keyframe interpolator: implication check failed");
// a holds at an edge, so b holds at the next edge
`define KLI_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("keyframe interpolator: next-cycle check failed");
`else
`define KLI_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define KLI_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[hw/rtl/kli_pkg.sv]
// Shared constants for the keyframe linear interpolator.
// No dependencies.
`default_nettype none
package kli_pkg;

    localparam int CHANNELS        = 6;
    localparam int DEF_MAX_KEYFRAMES = 64;
    localparam int DATA_W          = 32;
    localparam int STEPS_W         = 10;
    localparam int SEG_OUT_W       = 6;
    localparam int DIV_CNT_W       = 5;
    localparam int CH_W            = 3;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd100;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_START  = 2'd3;

endpackage
`default_nettype wire

[hw/rtl/keyframe_linear_interpolator_top.sv]
// Keyframe interpolator: pose registers, keyframe memory, serial divider, sequencer.
// Depends on kli_pkg and keyframe_linear_interpolator_top_assert.svh.
// Set pose, stop, full append, last or idle tick go straight to the result; append stores six
// channels; a pose step adds six increments; start or segment change runs a 32-step divide per channel.
// One item in flight; the next beat is taken in the cycle after the result loads.
// Reset clears pose, increments, counters and flags; the keyframe memory is left as is.
`default_nettype none
`include "keyframe_linear_interpolator_top_assert.svh"
module keyframe_linear_interpolator_top
    import kli_pkg::*;
#(
    parameter int MAX_KEYFRAMES = DEF_MAX_KEYFRAMES
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [STEPS_W-1:0]          cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_op,
    input  wire logic signed [DATA_W-1:0]    s_in_pos_x,
    input  wire logic signed [DATA_W-1:0]    s_in_pos_y,
    input  wire logic signed [DATA_W-1:0]    s_in_pos_z,
    input  wire logic signed [DATA_W-1:0]    s_in_rot_x,
    input  wire logic signed [DATA_W-1:0]    s_in_rot_y,
    input  wire logic signed [DATA_W-1:0]    s_in_rot_z,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [DATA_W-1:0]         m_out_pos_x,
    output logic signed [DATA_W-1:0]         m_out_pos_y,
    output logic signed [DATA_W-1:0]         m_out_pos_z,
    output logic signed [DATA_W-1:0]         m_out_rot_x,
    output logic signed [DATA_W-1:0]         m_out_rot_y,
    output logic signed [DATA_W-1:0]         m_out_rot_z,
    output logic                             m_playing,
    output logic [SEG_OUT_W-1:0]             m_segment,
    output logic                             m_finished,
    output logic                             m_table_full
);

    localparam int FC_W   = $clog2(MAX_KEYFRAMES + 1);
    localparam int SEG_W  = $clog2(MAX_KEYFRAMES);
    localparam int DEPTH  = MAX_KEYFRAMES * CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_APPEND = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_RD_A   = 3'd3;
    localparam logic [2:0] S_RD_B   = 3'd4;
    localparam logic [2:0] S_SETUP  = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(CHANNELS);
    localparam logic [CH_W-1:0]   CH_LAST  = CH_W'(CHANNELS - 1);

    logic [2:0]            state_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [DATA_W-1:0]     pose_reg [CHANNELS];
    logic [DATA_W-1:0]     inc_reg  [CHANNELS];
    logic [FC_W-1:0]       frame_count_reg;
    logic [ADDR_W-1:0]     frame_base_reg;
    logic                  play_reg;
    logic [SEG_W-1:0]      seg_reg;
    logic [ADDR_W-1:0]     seg_base_reg;
    logic [STEPS_W-1:0]    step_count_reg;
    logic [STEPS_W-1:0]    steps_reg;
    logic                  load_pose_reg;
    logic                  finished_reg;
    logic                  full_reg;

    // divider datapath
    logic [DATA_W-1:0]     a_reg;
    logic [DATA_W-1:0]     quo_reg;
    logic [STEPS_W-1:0]    rem_reg;
    logic [STEPS_W-1:0]    div_reg;
    logic                  neg_reg;
    logic [DIV_CNT_W-1:0]  bit_cnt_reg;

    logic [DATA_W-1:0]     mem [DEPTH];
    logic [DATA_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;

    logic                  s_accept;
    logic                  out_free;
    logic                  seg_last;
    logic [DATA_W:0]       diff;
    logic [DATA_W-1:0]     mag;
    logic [STEPS_W:0]      shifted;
    logic                  fits;
    logic [STEPS_W-1:0]    rem_next;
    logic [DATA_W-1:0]     quo_next;
    logic [DATA_W-1:0]     inc_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid || m_ready;

    // the tick that leaves segment seg_reg ends playback when no next pair remains
    assign seg_last = ((FC_W+1)'(seg_reg) + (FC_W+1)'(2)) >= (FC_W+1)'(frame_count_reg);

    assign rd_addr = (state_reg == S_RD_A) ? seg_base_reg + ADDR_W'(ch_reg)
                                           : seg_base_reg + ROW_STEP + ADDR_W'(ch_reg);
    assign wr_addr = frame_base_reg + ADDR_W'(ch_reg);

    assign diff = {rd_data_reg[DATA_W-1], rd_data_reg} - {a_reg[DATA_W-1], a_reg};
    assign mag  = diff[DATA_W] ? DATA_W'(~diff + 1'b1) : diff[DATA_W-1:0];

    assign shifted  = {rem_reg, quo_reg[DATA_W-1]};
    assign fits     = shifted >= {1'b0, div_reg};
    assign rem_next = fits ? STEPS_W'(shifted - {1'b0, div_reg}) : shifted[STEPS_W-1:0];
    assign quo_next = {quo_reg[DATA_W-2:0], fits};
    assign inc_next = neg_reg ? (~quo_next + 1'b1) : quo_next;

    always_ff @(posedge aclk) begin
        if (state_reg == S_APPEND) begin
            mem[wr_addr] <= pose_reg[ch_reg];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_RD_B: begin
                a_reg <= rd_data_reg;
            end
            S_SETUP: begin
                quo_reg     <= mag;
                rem_reg     <= '0;
                neg_reg     <= diff[DATA_W];
                div_reg     <= (steps_reg == '0) ? STEPS_W'(1) : steps_reg;
                bit_cnt_reg <= '0;
            end
            S_DIV: begin
                quo_reg     <= quo_next;
                rem_reg     <= rem_next;
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            ch_reg          <= '0;
            frame_count_reg <= '0;
            frame_base_reg  <= '0;
            play_reg        <= 1'b0;
            seg_reg         <= '0;
            seg_base_reg    <= '0;
            step_count_reg  <= '0;
            steps_reg       <= STEPS_RESET;
            load_pose_reg   <= 1'b0;
            finished_reg    <= 1'b0;
            full_reg        <= 1'b0;
            m_valid         <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                pose_reg[c] <= '0;
                inc_reg[c]  <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                steps_reg <= cfg_data;
            end
            // S_DONE reloads the output register itself
            if (m_valid && m_ready && state_reg != S_DONE) begin
                m_valid <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        finished_reg  <= (s_op == OP_TICK) && play_reg &&
                                         (step_count_reg >= steps_reg) && seg_last;
                        full_reg      <= (s_op == OP_APPEND) &&
                                         (frame_count_reg >= FC_W'(MAX_KEYFRAMES));
                        load_pose_reg <= (s_op == OP_START) && !play_reg &&
                                         (frame_count_reg > FC_W'(1));
                        ch_reg        <= '0;
                        unique case (s_op)
                            OP_SET: begin
                                pose_reg[0] <= s_in_pos_x;
                                pose_reg[1] <= s_in_pos_y;
                                pose_reg[2] <= s_in_pos_z;
                                pose_reg[3] <= s_in_rot_x;
                                pose_reg[4] <= s_in_rot_y;
                                pose_reg[5] <= s_in_rot_z;
                                state_reg   <= S_DONE;
                            end
                            OP_APPEND: begin
                                if (frame_count_reg < FC_W'(MAX_KEYFRAMES)) begin
                                    state_reg <= S_APPEND;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_START: begin
                                if (play_reg) begin
                                    play_reg  <= 1'b0;
                                    state_reg <= S_DONE;
                                end else if (frame_count_reg > FC_W'(1)) begin
                                    seg_reg        <= '0;
                                    seg_base_reg   <= '0;
                                    step_count_reg <= '0;
                                    play_reg       <= 1'b1;
                                    state_reg      <= S_RD_A;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_TICK: begin
                                if (play_reg) begin
                                    if (step_count_reg >= steps_reg) begin
                                        if (seg_last) begin
                                            seg_reg      <= '0;
                                            seg_base_reg <= '0;
                                            play_reg     <= 1'b0;
                                            state_reg    <= S_DONE;
                                        end else begin
                                            seg_reg        <= seg_reg + 1'b1;
                                            seg_base_reg   <= seg_base_reg + ROW_STEP;
                                            step_count_reg <= '0;
                                            state_reg      <= S_RD_A;
                                        end
                                    end else begin
                                        step_count_reg <= step_count_reg + 1'b1;
                                        state_reg      <= S_ADD;
                                    end
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_APPEND: begin
                    ch_reg <= ch_reg + 1'b1;
                    if (ch_reg == CH_LAST) begin
                        frame_count_reg <= frame_count_reg + 1'b1;
                        frame_base_reg  <= frame_base_reg + ROW_STEP;
                        state_reg       <= S_DONE;
                    end
                end
                S_ADD: begin
                    pose_reg[ch_reg] <= pose_reg[ch_reg] + inc_reg[ch_reg];
                    ch_reg           <= ch_reg + 1'b1;
                    if (ch_reg == CH_LAST) begin
                        state_reg <= S_DONE;
                    end
                end
                S_RD_A: begin
                    state_reg <= S_RD_B;
                end
                S_RD_B: begin
                    state_reg <= S_SETUP;
                end
                S_SETUP: begin
                    // on start the pose takes keyframe 0
                    if (load_pose_reg) begin
                        pose_reg[ch_reg] <= a_reg;
                    end
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (bit_cnt_reg == DIV_CNT_W'(DATA_W - 1)) begin
                        inc_reg[ch_reg] <= inc_next;
                        ch_reg          <= ch_reg + 1'b1;
                        state_reg       <= (ch_reg == CH_LAST) ? S_DONE : S_RD_A;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        m_valid   <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_out_pos_x  <= pose_reg[0];
            m_out_pos_y  <= pose_reg[1];
            m_out_pos_z  <= pose_reg[2];
            m_out_rot_x  <= pose_reg[3];
            m_out_rot_y  <= pose_reg[4];
            m_out_rot_z  <= pose_reg[5];
            m_playing    <= play_reg;
            m_segment    <= SEG_OUT_W'(seg_reg);
            m_finished   <= finished_reg;
            m_table_full <= full_reg;
        end
    end

    `KLI_ASSERT_IMPLY(a_play_frames, aclk, aresetn, play_reg, frame_count_reg > FC_W'(1))
    `KLI_ASSERT_IMPLY(a_play_seg, aclk, aresetn, play_reg,
        ((FC_W+1)'(seg_reg) + (FC_W+1)'(1)) < (FC_W+1)'(frame_count_reg))
    `KLI_ASSERT_IMPLY(a_div_nonzero, aclk, aresetn, state_reg == S_DIV, div_reg != '0)
    `KLI_ASSERT_NEXT(a_done_load, aclk, aresetn, state_reg == S_DONE && out_free,
        m_valid && state_reg == S_IDLE)

endmodule
`default_nettype wire
